### hdl/sfcs_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the spi flash command sequencer
// no dependencies; used by every module under hdl
package sfcs_pkg;

  // device geometry in bytes
  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_BYTES = 4096;
  localparam int BLOCK_BYTES  = 65536;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);

  // configuration register widths and indexes
  localparam int PAGE_COUNT_W   = 25;
  localparam int SECTOR_COUNT_W = 21;
  localparam int BLOCK_COUNT_W  = 17;
  localparam int CFG_DATA_W     = 25;
  localparam int CFG_INDEX_W    = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAGE_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SECTOR_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT  = 2'd2;
  localparam logic [PAGE_COUNT_W-1:0]   PAGE_COUNT_RESET   = 25'd65536;
  localparam logic [SECTOR_COUNT_W-1:0] SECTOR_COUNT_RESET = 21'd4096;
  localparam logic [BLOCK_COUNT_W-1:0]  BLOCK_COUNT_RESET  = 17'd256;
  localparam logic [BLOCK_COUNT_W-1:0]  WIDE_ADDR_BLOCKS   = 17'd512;

  // stream widths
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 24;

  // request codes
  localparam logic [3:0] ACT_WREN    = 4'd0;
  localparam logic [3:0] ACT_WRDI    = 4'd1;
  localparam logic [3:0] ACT_RDSR    = 4'd2;
  localparam logic [3:0] ACT_WRSR    = 4'd3;
  localparam logic [3:0] ACT_PROGRAM = 4'd4;
  localparam logic [3:0] ACT_READ    = 4'd5;
  localparam logic [3:0] ACT_SE      = 4'd6;
  localparam logic [3:0] ACT_BE32    = 4'd7;
  localparam logic [3:0] ACT_CE      = 4'd8;
  localparam logic [3:0] ACT_QPI     = 4'd9;
  localparam logic [3:0] ACT_REPLY   = 4'd10;
  localparam logic [3:0] ACT_TICK    = 4'd11;

  // flash opcodes
  localparam logic [7:0] OP_WREN    = 8'h06;
  localparam logic [7:0] OP_WRDI    = 8'h04;
  localparam logic [7:0] OP_RDSR    = 8'h05;
  localparam logic [7:0] OP_DUMMY   = 8'hA5;
  localparam logic [7:0] OP_WRSR    = 8'h01;
  localparam logic [7:0] OP_READ3   = 8'h03;
  localparam logic [7:0] OP_READ4   = 8'h13;
  localparam logic [7:0] OP_PP3     = 8'h02;
  localparam logic [7:0] OP_PP4     = 8'h12;
  localparam logic [7:0] OP_SE3     = 8'h20;
  localparam logic [7:0] OP_SE4     = 8'h21;
  localparam logic [7:0] OP_BE32_3  = 8'h52;
  localparam logic [7:0] OP_BE32_4  = 8'h5C;
  localparam logic [7:0] OP_CE      = 8'hC7;
  localparam logic [7:0] OP_QPI     = 8'h35;

  // outcome codes
  localparam logic [2:0] OUT_SENT       = 3'd0;
  localparam logic [2:0] OUT_BAD_NUMBER = 3'd1;
  localparam logic [2:0] OUT_BAD_OFFSET = 3'd2;
  localparam logic [2:0] OUT_BUSY       = 3'd3;
  localparam logic [2:0] OUT_DONE       = 3'd4;
  localparam logic [2:0] OUT_TIMEOUT    = 3'd5;

  // wait limits in ticks
  localparam logic [31:0] LIMIT_PROGRAM = 32'd100;
  localparam logic [31:0] LIMIT_SECTOR  = 32'd1000;
  localparam logic [31:0] LIMIT_BLOCK   = 32'd3000;
  localparam logic [9:0]  CE_TICKS_PER_BLOCK = 10'd1000;

  localparam int ACC_W       = 9;
  localparam int MAX_RESULTS = 6;
  localparam int CNT_W       = 3;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // one classified request: all results it produces
  typedef struct packed {
    logic [CNT_W-1:0]            count;
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [MAX_RESULTS-1:0]      ends;
    logic                        has_byte;
    logic [ACC_W-1:0]            acc;
    logic [2:0]                  outcome;
  } cmd_rec_t;

endpackage

### hdl/sfcs_front.sv
`timescale 1ns / 1ps
// front end: configuration registers, wait state and request classification
// depends on sfcs_pkg
module sfcs_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sfcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sfcs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sfcs_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                                q_full,
  output logic                                push,
  output sfcs_pkg::cmd_rec_t                  rec
);

  logic [sfcs_pkg::PAGE_COUNT_W-1:0]   page_count;
  logic [sfcs_pkg::SECTOR_COUNT_W-1:0] sector_count;
  logic [sfcs_pkg::BLOCK_COUNT_W-1:0]  block_count;
  logic        waiting, waiting_next;
  logic [31:0] elapsed, elapsed_next;
  logic [31:0] limit, limit_next;

  logic [3:0]  action;
  logic [31:0] number;
  logic [7:0]  offset;
  logic [31:0] length;
  logic [7:0]  value;
  logic        accept;
  logic        wide;
  logic [31:0] tick_count;
  logic [8:0]  room;
  logic [31:0] ce_limit;

  assign action = s_tdata[3:0];
  assign number = s_tdata[35:4];
  assign offset = s_tdata[43:36];
  assign length = s_tdata[75:44];
  assign value  = s_tdata[83:76];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && !q_full;
  assign wide     = block_count >= sfcs_pkg::WIDE_ADDR_BLOCKS;
  assign tick_count = (elapsed == 32'hFFFF_FFFF) ? elapsed : elapsed + 32'd1;
  assign room       = 9'(sfcs_pkg::PAGE_BYTES) - {1'b0, offset};
  assign ce_limit   = 32'(block_count) * 32'(sfcs_pkg::CE_TICKS_PER_BLOCK);

  // opcode and address bytes starting at pos
  function automatic sfcs_pkg::cmd_rec_t put_addr(
    sfcs_pkg::cmd_rec_t           r,
    logic [sfcs_pkg::CNT_W-1:0]   pos,
    logic [7:0]                   op3,
    logic [7:0]                   op4,
    logic [31:0]                  addr,
    logic                         close,
    logic                         wide4
  );
    sfcs_pkg::cmd_rec_t q;
    q = r;
    q.has_byte = 1'b1;
    if (wide4) begin
      q.bytes[pos]              = op4;
      q.bytes[3'(pos + 3'd1)]   = addr[31:24];
      q.bytes[3'(pos + 3'd2)]   = addr[23:16];
      q.bytes[3'(pos + 3'd3)]   = addr[15:8];
      q.bytes[3'(pos + 3'd4)]   = addr[7:0];
      q.ends[3'(pos + 3'd4)]    = close;
      q.count                   = 3'(pos + 3'd5);
    end else begin
      q.bytes[pos]              = op3;
      q.bytes[3'(pos + 3'd1)]   = addr[23:16];
      q.bytes[3'(pos + 3'd2)]   = addr[15:8];
      q.bytes[3'(pos + 3'd3)]   = addr[7:0];
      q.ends[3'(pos + 3'd3)]    = close;
      q.count                   = 3'(pos + 3'd4);
    end
    return q;
  endfunction

  always_comb begin
    rec          = '0;
    waiting_next = waiting;
    elapsed_next = elapsed;
    limit_next   = limit;
    if (waiting && action <= sfcs_pkg::ACT_QPI) begin
      rec.count   = 3'd1;
      rec.outcome = sfcs_pkg::OUT_BUSY;
    end else begin
      unique case (action)
        sfcs_pkg::ACT_REPLY: begin
          if (waiting) begin
            rec.count = 3'd1;
            if (!value[0]) begin
              rec.has_byte = 1'b1;
              rec.bytes[0] = sfcs_pkg::OP_WRDI;
              rec.ends[0]  = 1'b1;
              rec.outcome  = sfcs_pkg::OUT_DONE;
              waiting_next = 1'b0;
            end else begin
              rec.outcome  = sfcs_pkg::OUT_BUSY;
            end
          end
        end
        sfcs_pkg::ACT_TICK: begin
          if (waiting) begin
            elapsed_next = tick_count;
            rec.has_byte = 1'b1;
            if (tick_count >= limit) begin
              rec.count    = 3'd1;
              rec.bytes[0] = sfcs_pkg::OP_WRDI;
              rec.ends[0]  = 1'b1;
              rec.outcome  = sfcs_pkg::OUT_TIMEOUT;
              waiting_next = 1'b0;
            end else begin
              rec.count    = 3'd2;
              rec.bytes[0] = sfcs_pkg::OP_RDSR;
              rec.bytes[1] = sfcs_pkg::OP_DUMMY;
              rec.ends[1]  = 1'b1;
              rec.outcome  = sfcs_pkg::OUT_BUSY;
            end
          end
        end
        sfcs_pkg::ACT_WREN: begin
          rec.count = 3'd1; rec.has_byte = 1'b1;
          rec.bytes[0] = sfcs_pkg::OP_WREN; rec.ends[0] = 1'b1;
        end
        sfcs_pkg::ACT_WRDI: begin
          rec.count = 3'd1; rec.has_byte = 1'b1;
          rec.bytes[0] = sfcs_pkg::OP_WRDI; rec.ends[0] = 1'b1;
        end
        sfcs_pkg::ACT_RDSR: begin
          rec.count = 3'd2; rec.has_byte = 1'b1;
          rec.bytes[0] = sfcs_pkg::OP_RDSR;
          rec.bytes[1] = sfcs_pkg::OP_DUMMY; rec.ends[1] = 1'b1;
        end
        sfcs_pkg::ACT_WRSR: begin
          rec.count = 3'd3; rec.has_byte = 1'b1;
          rec.bytes[0] = sfcs_pkg::OP_WREN; rec.ends[0] = 1'b1;
          rec.bytes[1] = sfcs_pkg::OP_WRSR;
          rec.bytes[2] = value; rec.ends[2] = 1'b1;
        end
        sfcs_pkg::ACT_PROGRAM: begin
          rec.count = 3'd1; rec.has_byte = 1'b1;
          rec.bytes[0] = sfcs_pkg::OP_WRDI; rec.ends[0] = 1'b1;
          if (number >= 32'(page_count)) begin
            rec.outcome = sfcs_pkg::OUT_BAD_NUMBER;
          end else if (32'(offset) >= 32'(sfcs_pkg::PAGE_BYTES)) begin
            rec.outcome = sfcs_pkg::OUT_BAD_OFFSET;
          end else begin
            rec.bytes[0] = sfcs_pkg::OP_WREN;
            rec.acc = (length > 32'(room)) ? room : length[8:0];
            rec = put_addr(rec, 3'd1, sfcs_pkg::OP_PP3, sfcs_pkg::OP_PP4,
                           (number << sfcs_pkg::PAGE_SHIFT) | 32'(offset),
                           1'b0, wide);
            waiting_next = 1'b1;
            elapsed_next = '0;
            limit_next   = sfcs_pkg::LIMIT_PROGRAM;
          end
        end
        sfcs_pkg::ACT_READ: begin
          rec = put_addr(rec, 3'd0, sfcs_pkg::OP_READ3, sfcs_pkg::OP_READ4,
                         number, 1'b0, wide);
        end
        sfcs_pkg::ACT_SE: begin
          rec.count = 3'd1; rec.has_byte = 1'b1;
          rec.bytes[0] = sfcs_pkg::OP_WRDI; rec.ends[0] = 1'b1;
          if (number >= 32'(sector_count)) begin
            rec.outcome = sfcs_pkg::OUT_BAD_NUMBER;
          end else begin
            rec.bytes[0] = sfcs_pkg::OP_WREN;
            rec = put_addr(rec, 3'd1, sfcs_pkg::OP_SE3, sfcs_pkg::OP_SE4,
                           number << sfcs_pkg::SECTOR_SHIFT, 1'b1, wide);
            waiting_next = 1'b1;
            elapsed_next = '0;
            limit_next   = sfcs_pkg::LIMIT_SECTOR;
          end
        end
        sfcs_pkg::ACT_BE32: begin
          rec.count = 3'd1; rec.has_byte = 1'b1;
          rec.bytes[0] = sfcs_pkg::OP_WRDI; rec.ends[0] = 1'b1;
          if (number >= 32'(block_count)) begin
            rec.outcome = sfcs_pkg::OUT_BAD_NUMBER;
          end else begin
            rec.bytes[0] = sfcs_pkg::OP_WREN;
            rec = put_addr(rec, 3'd1, sfcs_pkg::OP_BE32_3, sfcs_pkg::OP_BE32_4,
                           number << sfcs_pkg::BLOCK_SHIFT, 1'b1, wide);
            waiting_next = 1'b1;
            elapsed_next = '0;
            limit_next   = sfcs_pkg::LIMIT_BLOCK;
          end
        end
        sfcs_pkg::ACT_CE: begin
          rec.count = 3'd2; rec.has_byte = 1'b1;
          rec.bytes[0] = sfcs_pkg::OP_WREN; rec.ends[0] = 1'b1;
          rec.bytes[1] = sfcs_pkg::OP_CE;   rec.ends[1] = 1'b1;
          waiting_next = 1'b1;
          elapsed_next = '0;
          limit_next   = ce_limit;
        end
        sfcs_pkg::ACT_QPI: begin
          rec.count = 3'd1; rec.has_byte = 1'b1;
          rec.bytes[0] = sfcs_pkg::OP_QPI; rec.ends[0] = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // empty runs go nowhere
  assign push = accept && (rec.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      page_count   <= sfcs_pkg::PAGE_COUNT_RESET;
      sector_count <= sfcs_pkg::SECTOR_COUNT_RESET;
      block_count  <= sfcs_pkg::BLOCK_COUNT_RESET;
      waiting      <= 1'b0;
      elapsed      <= '0;
      limit        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sfcs_pkg::REG_PAGE_COUNT:   page_count   <= cfg_data[sfcs_pkg::PAGE_COUNT_W-1:0];
          sfcs_pkg::REG_SECTOR_COUNT: sector_count <= cfg_data[sfcs_pkg::SECTOR_COUNT_W-1:0];
          sfcs_pkg::REG_BLOCK_COUNT:  block_count  <= cfg_data[sfcs_pkg::BLOCK_COUNT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        waiting <= waiting_next;
        elapsed <= elapsed_next;
        limit   <= limit_next;
      end
    end
  end

endmodule

### hdl/sfcs_queue.sv
`timescale 1ns / 1ps
// small fifo of classified requests between front and back end
// depends on sfcs_pkg
module sfcs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sfcs_pkg::cmd_rec_t push_rec,
  input  logic               pop,
  output sfcs_pkg::cmd_rec_t head,
  output logic               full,
  output logic               empty
);

  sfcs_pkg::cmd_rec_t mem [sfcs_pkg::QUEUE_DEPTH];
  logic [sfcs_pkg::QUEUE_AW-1:0] wptr, rptr;
  logic [sfcs_pkg::QUEUE_AW:0]   fill;

  assign head  = mem[rptr];
  assign full  = fill == (sfcs_pkg::QUEUE_AW+1)'(sfcs_pkg::QUEUE_DEPTH);
  assign empty = fill == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hdl/sfcs_back.sv
`timescale 1ns / 1ps
// back end: walks the head request one result per cycle, while the sink is
// ready, into the output register; depends on sfcs_pkg
module sfcs_back (
  input  logic                               clk,
  input  logic                               rst,
  input  sfcs_pkg::cmd_rec_t                 head,
  input  logic                               empty,
  output logic                               pop,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sfcs_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                               m_tlast
);

  logic [sfcs_pkg::CNT_W-1:0] idx;
  logic                       load;
  logic                       run_end;
  logic [7:0]                 out_byte;
  logic                       byte_valid;
  logic                       frame_end;
  logic [sfcs_pkg::ACC_W-1:0] acc;
  logic [2:0]                 outcome;

  assign load    = !empty && (!m_tvalid || m_tready);
  assign run_end = 3'(idx + 3'd1) == head.count;
  assign pop     = load && run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= run_end ? '0 : 3'(idx + 3'd1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= head.bytes[idx];
      byte_valid <= head.has_byte;
      frame_end  <= head.ends[idx];
      acc        <= head.acc;
      outcome    <= head.outcome;
      m_tlast    <= run_end;
    end
  end

  assign m_tdata = {2'b00, outcome, acc, frame_end, byte_valid, out_byte};

endmodule

### hdl/spi_flash_command_sequencer.sv
`timescale 1ns / 1ps
// top level of the spi nor flash command sequencer
// depends on sfcs_pkg, sfcs_front, sfcs_queue, sfcs_back
//
// Turns flash requests into the command and address bytes to shift out on
// spi, one result transaction per byte (or one status-only transaction when
// the device is busy; a refused request gets a write-disable byte). Writes
// get a write-enable frame first; program and erase then hold the block in a
// wait in which tick requests poll the status register and a status reply
// with wip clear, or the tick limit, sends the closing write-disable byte.
// The front end takes one request per cycle while its four-entry queue has
// room and updates the wait state at once; the back end emits one result per
// cycle while the sink is ready, and a request that yields n results (1 to 6,
// 6 for a four-byte address program header) holds the back end until all n
// are out before the next queued request starts. Requests that yield nothing
// (idle tick or reply, unused codes) never reach the queue. Configuration
// writes are taken at any cycle and should be made only while idle.
module spi_flash_command_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [sfcs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sfcs_pkg::CFG_DATA_W-1:0]    cfg_data,
  // request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // action[3:0], number[35:4], offset[43:36], length[75:44], value[83:76], zero fill
  input  logic [sfcs_pkg::IN_TDATA_W-1:0]    s_tdata,
  // result stream, tlast marks the final result of a request
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_byte[7:0], byte_valid[8], frame_end[9], accepted_length[18:10],
  // outcome[21:19], zero fill
  output logic [sfcs_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                               m_tlast
);

  sfcs_pkg::cmd_rec_t front_rec;
  sfcs_pkg::cmd_rec_t head;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;

  // classification and wait-state bookkeeping
  sfcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .rec       (front_rec)
  );

  // decouples request intake from byte emission
  sfcs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (front_rec),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // byte sequencing into the registered output
  sfcs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### dv/sfcs_scoreboard.sv
`timescale 1ns / 1ps
// result scoreboard for the spi flash command sequencer: predicts the command
// bytes of every accepted request and compares them with the result stream
// depends on sfcs_pkg for codes, opcodes, limits and stream widths
module sfcs_scoreboard (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sfcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [sfcs_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [sfcs_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             m_tlast,
  output int                               errors,
  output int                               outstanding
);

  typedef struct {
    logic [7:0]                 data_byte;
    logic                       byte_valid;
    logic                       frame_end;
    logic [sfcs_pkg::ACC_W-1:0] acc_len;
    logic [2:0]                 outcome;
    logic                       last;
  } spi_result_t;

  spi_result_t spi_result_q[$];
  spi_result_t scratch[sfcs_pkg::MAX_RESULTS];
  int          scratch_n;

  // shadow of the device geometry and the busy wait
  logic [sfcs_pkg::PAGE_COUNT_W-1:0]   pg_count;
  logic [sfcs_pkg::SECTOR_COUNT_W-1:0] sec_count;
  logic [sfcs_pkg::BLOCK_COUNT_W-1:0]  blk_count;
  logic                                in_wait;
  logic [31:0]                         tick_count;
  logic [31:0]                         tick_cap;

  initial errors = 0;

  task automatic log_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic add_beat(input logic [7:0] b, input logic v, input logic e,
                          input logic [sfcs_pkg::ACC_W-1:0] acc, input logic [2:0] oc);
    scratch[scratch_n] = '{b, v, e, acc, oc, 1'b0};
    scratch_n++;
  endtask

  // opcode then three or four address bytes, msb first
  task automatic add_addr(input logic [7:0] op3, input logic [7:0] op4,
                          input logic [31:0] addr,
                          input logic [sfcs_pkg::ACC_W-1:0] acc,
                          input logic close);
    logic wide;
    int   sh;
    wide = (blk_count >= sfcs_pkg::WIDE_ADDR_BLOCKS);
    add_beat(wide ? op4 : op3, 1'b1, 1'b0, acc, sfcs_pkg::OUT_SENT);
    for (sh = wide ? 24 : 16; sh >= 0; sh -= 8)
      add_beat(8'(addr >> sh), 1'b1, close && (sh == 0), acc, sfcs_pkg::OUT_SENT);
  endtask

  task automatic begin_wait(input logic [31:0] cap);
    in_wait    = 1'b1;
    tick_count = '0;
    tick_cap   = cap;
  endtask

  task automatic expand_request(input logic [sfcs_pkg::IN_TDATA_W-1:0] d);
    logic [3:0]                 act;
    logic [31:0]                num;
    logic [7:0]                 ofs;
    logic [31:0]                len;
    logic [7:0]                 val;
    logic [31:0]                room;
    logic [31:0]                addr;
    logic [sfcs_pkg::ACC_W-1:0] acc;
    act = d[3:0];
    num = d[35:4];
    ofs = d[43:36];
    len = d[75:44];
    val = d[83:76];
    scratch_n = 0;
    if (in_wait && act <= sfcs_pkg::ACT_QPI) begin
      add_beat(8'h00, 1'b0, 1'b0, '0, sfcs_pkg::OUT_BUSY);
    end else begin
      case (act)
        sfcs_pkg::ACT_REPLY: begin
          if (in_wait) begin
            if (!val[0]) begin
              add_beat(sfcs_pkg::OP_WRDI, 1'b1, 1'b1, '0, sfcs_pkg::OUT_DONE);
              in_wait = 1'b0;
            end else begin
              add_beat(8'h00, 1'b0, 1'b0, '0, sfcs_pkg::OUT_BUSY);
            end
          end
        end
        sfcs_pkg::ACT_TICK: begin
          if (in_wait) begin
            if (tick_count != '1) tick_count++;
            if (tick_count >= tick_cap) begin
              add_beat(sfcs_pkg::OP_WRDI, 1'b1, 1'b1, '0, sfcs_pkg::OUT_TIMEOUT);
              in_wait = 1'b0;
            end else begin
              add_beat(sfcs_pkg::OP_RDSR, 1'b1, 1'b0, '0, sfcs_pkg::OUT_BUSY);
              add_beat(sfcs_pkg::OP_DUMMY, 1'b1, 1'b1, '0, sfcs_pkg::OUT_BUSY);
            end
          end
        end
        sfcs_pkg::ACT_WREN: add_beat(sfcs_pkg::OP_WREN, 1'b1, 1'b1, '0, sfcs_pkg::OUT_SENT);
        sfcs_pkg::ACT_WRDI: add_beat(sfcs_pkg::OP_WRDI, 1'b1, 1'b1, '0, sfcs_pkg::OUT_SENT);
        sfcs_pkg::ACT_RDSR: begin
          add_beat(sfcs_pkg::OP_RDSR, 1'b1, 1'b0, '0, sfcs_pkg::OUT_SENT);
          add_beat(sfcs_pkg::OP_DUMMY, 1'b1, 1'b1, '0, sfcs_pkg::OUT_SENT);
        end
        sfcs_pkg::ACT_WRSR: begin
          add_beat(sfcs_pkg::OP_WREN, 1'b1, 1'b1, '0, sfcs_pkg::OUT_SENT);
          add_beat(sfcs_pkg::OP_WRSR, 1'b1, 1'b0, '0, sfcs_pkg::OUT_SENT);
          add_beat(val, 1'b1, 1'b1, '0, sfcs_pkg::OUT_SENT);
        end
        sfcs_pkg::ACT_PROGRAM: begin
          if (num >= {7'd0, pg_count}) begin
            add_beat(sfcs_pkg::OP_WRDI, 1'b1, 1'b1, '0, sfcs_pkg::OUT_BAD_NUMBER);
          end else if (ofs >= sfcs_pkg::PAGE_BYTES) begin
            add_beat(sfcs_pkg::OP_WRDI, 1'b1, 1'b1, '0, sfcs_pkg::OUT_BAD_OFFSET);
          end else begin
            room = 32'(sfcs_pkg::PAGE_BYTES) - {24'd0, ofs};
            acc  = (len > room) ? room[sfcs_pkg::ACC_W-1:0] : len[sfcs_pkg::ACC_W-1:0];
            addr = num * 32'(sfcs_pkg::PAGE_BYTES) + {24'd0, ofs};
            add_beat(sfcs_pkg::OP_WREN, 1'b1, 1'b1, acc, sfcs_pkg::OUT_SENT);
            // header frame stays open after the last address byte
            add_addr(sfcs_pkg::OP_PP3, sfcs_pkg::OP_PP4, addr, acc, 1'b0);
            begin_wait(sfcs_pkg::LIMIT_PROGRAM);
          end
        end
        sfcs_pkg::ACT_READ:
          add_addr(sfcs_pkg::OP_READ3, sfcs_pkg::OP_READ4, num, '0, 1'b0);
        sfcs_pkg::ACT_SE: begin
          if (num >= {11'd0, sec_count}) begin
            add_beat(sfcs_pkg::OP_WRDI, 1'b1, 1'b1, '0, sfcs_pkg::OUT_BAD_NUMBER);
          end else begin
            add_beat(sfcs_pkg::OP_WREN, 1'b1, 1'b1, '0, sfcs_pkg::OUT_SENT);
            add_addr(sfcs_pkg::OP_SE3, sfcs_pkg::OP_SE4,
                     num * 32'(sfcs_pkg::SECTOR_BYTES), '0, 1'b1);
            begin_wait(sfcs_pkg::LIMIT_SECTOR);
          end
        end
        sfcs_pkg::ACT_BE32: begin
          if (num >= {15'd0, blk_count}) begin
            add_beat(sfcs_pkg::OP_WRDI, 1'b1, 1'b1, '0, sfcs_pkg::OUT_BAD_NUMBER);
          end else begin
            add_beat(sfcs_pkg::OP_WREN, 1'b1, 1'b1, '0, sfcs_pkg::OUT_SENT);
            add_addr(sfcs_pkg::OP_BE32_3, sfcs_pkg::OP_BE32_4,
                     num * 32'(sfcs_pkg::BLOCK_BYTES), '0, 1'b1);
            begin_wait(sfcs_pkg::LIMIT_BLOCK);
          end
        end
        sfcs_pkg::ACT_CE: begin
          add_beat(sfcs_pkg::OP_WREN, 1'b1, 1'b1, '0, sfcs_pkg::OUT_SENT);
          add_beat(sfcs_pkg::OP_CE, 1'b1, 1'b1, '0, sfcs_pkg::OUT_SENT);
          begin_wait({15'd0, blk_count} * 32'd1000);
        end
        sfcs_pkg::ACT_QPI: add_beat(sfcs_pkg::OP_QPI, 1'b1, 1'b1, '0, sfcs_pkg::OUT_SENT);
        default: ;
      endcase
    end
    if (scratch_n > 0) begin
      scratch[scratch_n-1].last = 1'b1;
      for (int i = 0; i < scratch_n; i++) spi_result_q.push_back(scratch[i]);
    end
  endtask

  task automatic check_result(input logic [sfcs_pkg::OUT_TDATA_W-1:0] d, input logic tl);
    spi_result_t w;
    if (spi_result_q.size() == 0) begin
      log_mismatch($sformatf("result %h with nothing expected", d));
    end else begin
      w = spi_result_q.pop_front();
      if (d[7:0] !== w.data_byte)
        log_mismatch($sformatf("out_byte %h, want %h", d[7:0], w.data_byte));
      if (d[8] !== w.byte_valid)
        log_mismatch($sformatf("byte_valid %b, want %b", d[8], w.byte_valid));
      if (d[9] !== w.frame_end)
        log_mismatch($sformatf("frame_end %b, want %b", d[9], w.frame_end));
      if (d[18:10] !== w.acc_len)
        log_mismatch($sformatf("accepted_length %0d, want %0d", d[18:10], w.acc_len));
      if (d[21:19] !== w.outcome)
        log_mismatch($sformatf("outcome %0d, want %0d", d[21:19], w.outcome));
      if (tl !== w.last)
        log_mismatch($sformatf("tlast %b, want %b", tl, w.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pg_count    = sfcs_pkg::PAGE_COUNT_RESET;
      sec_count   = sfcs_pkg::SECTOR_COUNT_RESET;
      blk_count   = sfcs_pkg::BLOCK_COUNT_RESET;
      in_wait     = 1'b0;
      tick_count  = '0;
      tick_cap    = '0;
      spi_result_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sfcs_pkg::REG_PAGE_COUNT:   pg_count  = cfg_data[sfcs_pkg::PAGE_COUNT_W-1:0];
          sfcs_pkg::REG_SECTOR_COUNT: sec_count = cfg_data[sfcs_pkg::SECTOR_COUNT_W-1:0];
          sfcs_pkg::REG_BLOCK_COUNT:  blk_count = cfg_data[sfcs_pkg::BLOCK_COUNT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expand_request(s_tdata);
      if (m_tvalid && m_tready) check_result(m_tdata, m_tlast);
      outstanding <= spi_result_q.size();
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// top of the spi flash command sequencer testbench: clock, reset, request
// stimulus, result back-pressure and the final verdict
// depends on sfcs_pkg, spi_flash_command_sequencer and sfcs_scoreboard
module tb;

  logic                             clk;
  logic                             rst       = 1'b1;
  logic                             cfg_we    = 1'b0;
  logic [sfcs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sfcs_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                             s_tvalid  = 1'b0;
  logic                             s_tready;
  logic [sfcs_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                             m_tvalid;
  logic                             m_tready  = 1'b0;
  logic [sfcs_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tlast;

  int errors;
  int outstanding;

  // when set, neither side idles: back-to-back requests, sink always ready
  bit quiet = 1'b0;

  // geometry as last written, used to aim numbers at the range edges
  int unsigned geo_pages   = 32'(sfcs_pkg::PAGE_COUNT_RESET);
  int unsigned geo_sectors = 32'(sfcs_pkg::SECTOR_COUNT_RESET);
  int unsigned geo_blocks  = 32'(sfcs_pkg::BLOCK_COUNT_RESET);

  // requests sent in the current traffic phase
  int phase_reqs;

  spi_flash_command_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  sfcs_scoreboard scoreboard (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result sink: ready runs broken by stalls of random length
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (m_tready && !quiet && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        hold = gap_len();
      end else begin
        m_tready <= 1'b1;
        hold = quiet ? 0 : $urandom_range(0, 6);
      end
    end
  end

  // one request transaction; valid stays up when the next follows at once
  task automatic send(input logic [3:0] act, input logic [31:0] num,
                      input logic [7:0] ofs, input logic [31:0] len,
                      input logic [7:0] val);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, val, len, ofs, num, act};
    do @(posedge clk); while (!s_tready);
  endtask

  // number near the top of the range, just past it, anywhere, zero, or inside
  function automatic logic [31:0] pick_number(input int unsigned count);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return count - 1;
    if (r < 25) return count;
    if (r < 33) return $urandom;
    if (r < 40) return 32'd0;
    return $urandom_range(0, count - 1);
  endfunction

  function automatic logic [7:0] pick_offset();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 8'hFF;
    if (r < 4) return 8'h00;
    return 8'($urandom);
  endfunction

  // program length: huge, exactly the page remainder, zero or modest
  function automatic logic [31:0] pick_len(input logic [7:0] ofs);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom;
    if (r < 55) return 32'(sfcs_pkg::PAGE_BYTES) - {24'd0, ofs};
    if (r < 65) return 32'd0;
    return $urandom_range(0, 400);
  endfunction

  // program or erase, then activity during the wait, then wip clear;
  // now and then the closing reply is dropped so the next one lands busy
  task automatic write_sequence();
    logic [3:0]  op;
    logic [31:0] num;
    logic [7:0]  ofs;
    int          extra;
    ofs = pick_offset();
    case ($urandom_range(0, 3))
      0:       begin op = sfcs_pkg::ACT_PROGRAM; num = pick_number(geo_pages);   end
      1:       begin op = sfcs_pkg::ACT_SE;      num = pick_number(geo_sectors); end
      2:       begin op = sfcs_pkg::ACT_BE32;    num = pick_number(geo_blocks);  end
      default: begin op = sfcs_pkg::ACT_CE;      num = $urandom;                 end
    endcase
    send(op, num, ofs, pick_len(ofs), 8'($urandom));
    phase_reqs++;
    extra = $urandom_range(0, 4);
    repeat (extra) begin
      case ($urandom_range(0, 2))
        0: send(sfcs_pkg::ACT_TICK, $urandom, 8'($urandom), $urandom, 8'($urandom));
        // wip still set
        1: send(sfcs_pkg::ACT_REPLY, $urandom, 8'($urandom), $urandom,
                8'($urandom) | 8'h01);
        // stray request while busy
        default: send(4'($urandom_range(0, 9)), $urandom, 8'($urandom), $urandom,
                      8'($urandom));
      endcase
      phase_reqs++;
    end
    if ($urandom_range(0, 9) != 0) begin
      send(sfcs_pkg::ACT_REPLY, $urandom, 8'($urandom), $urandom, 8'($urandom) & 8'hFE);
      phase_reqs++;
    end
  endtask

  task automatic single_command();
    logic [3:0] act;
    case ($urandom_range(0, 5))
      0:       act = sfcs_pkg::ACT_WREN;
      1:       act = sfcs_pkg::ACT_WRDI;
      2:       act = sfcs_pkg::ACT_RDSR;
      3:       act = sfcs_pkg::ACT_WRSR;
      4:       act = sfcs_pkg::ACT_READ;
      default: act = sfcs_pkg::ACT_QPI;
    endcase
    send(act, $urandom, 8'($urandom), $urandom, 8'($urandom));
    phase_reqs++;
  endtask

  task automatic run_traffic(input int quota);
    int r;
    phase_reqs = 0;
    while (phase_reqs < quota) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        write_sequence();
      end else if (r < 88) begin
        single_command();
      end else begin
        // tick, reply or unused code: not counted
        send(4'($urandom_range(sfcs_pkg::ACT_REPLY, 15)), $urandom, 8'($urandom),
             $urandom, 8'($urandom));
      end
    end
  endtask

  // close any open wait, drop valid and let the block drain fully
  task automatic settle(input int tail);
    send(sfcs_pkg::ACT_REPLY, 32'd0, 8'd0, 32'd0, 8'h00);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (tail) @(posedge clk);
  endtask

  // three back-to-back register writes; enable dropped after the last
  task automatic set_geometry(input int unsigned pages, input int unsigned sectors,
                              input int unsigned blocks);
    cfg_we    <= 1'b1;
    cfg_index <= sfcs_pkg::REG_PAGE_COUNT;
    cfg_data  <= pages[sfcs_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= sfcs_pkg::REG_SECTOR_COUNT;
    cfg_data  <= sectors[sfcs_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= sfcs_pkg::REG_BLOCK_COUNT;
    cfg_data  <= blocks[sfcs_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we      <= 1'b0;
    geo_pages   = pages;
    geo_sectors = sectors;
    geo_blocks  = blocks;
  endtask

  initial begin : stimulus
    int unsigned pg_list[5];
    int unsigned sec_list[5];
    int unsigned blk_list[5];
    // max, min, wide addressing threshold, just below it, random
    pg_list  = '{16777216, 1, 65536, 4096, 0};
    sec_list = '{1048576, 1, 4096, 256, 0};
    blk_list = '{65536, 1, 512, 511, 0};
    pg_list[4]  = $urandom_range(1, 16777216);
    sec_list[4] = $urandom_range(1, 1048576);
    blk_list[4] = $urandom_range(1, 65536);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pass on reset geometry, three-byte addressing
    send(sfcs_pkg::ACT_WREN, 32'd0, 8'd0, 32'd0, 8'd0);
    send(sfcs_pkg::ACT_WRDI, 32'd0, 8'd0, 32'd0, 8'd0);
    send(sfcs_pkg::ACT_RDSR, 32'd0, 8'd0, 32'd0, 8'd0);
    send(sfcs_pkg::ACT_WRSR, 32'd0, 8'd0, 32'd0, 8'hFF);
    send(sfcs_pkg::ACT_QPI, 32'd0, 8'd0, 32'd0, 8'd0);
    send(sfcs_pkg::ACT_READ, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    // page number at and far past the page count
    send(sfcs_pkg::ACT_PROGRAM, geo_pages, 8'd0, 32'd10, 8'd0);
    send(sfcs_pkg::ACT_PROGRAM, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    // last page, last byte: length clamps to one
    send(sfcs_pkg::ACT_PROGRAM, geo_pages - 1, 8'hFF, 32'hFFFF_FFFF, 8'd0);
    send(sfcs_pkg::ACT_WRDI, 32'd0, 8'd0, 32'd0, 8'd0);
    send(sfcs_pkg::ACT_TICK, 32'd0, 8'd0, 32'd0, 8'd0);
    send(sfcs_pkg::ACT_REPLY, 32'd0, 8'd0, 32'd0, 8'hFF);
    send(sfcs_pkg::ACT_REPLY, 32'd0, 8'd0, 32'd0, 8'hFE);
    // idle tick, idle reply and an unused code are dropped silently
    send(sfcs_pkg::ACT_TICK, 32'd0, 8'd0, 32'd0, 8'd0);
    send(sfcs_pkg::ACT_REPLY, 32'd0, 8'd0, 32'd0, 8'd0);
    send(4'd15, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    // full page program
    send(sfcs_pkg::ACT_PROGRAM, 32'd0, 8'd0, 32'd1000, 8'd0);
    send(sfcs_pkg::ACT_REPLY, 32'd0, 8'd0, 32'd0, 8'h00);
    send(sfcs_pkg::ACT_SE, geo_sectors, 8'd0, 32'd0, 8'd0);
    send(sfcs_pkg::ACT_SE, geo_sectors - 1, 8'd0, 32'd0, 8'd0);
    send(sfcs_pkg::ACT_REPLY, 32'd0, 8'd0, 32'd0, 8'h00);
    send(sfcs_pkg::ACT_BE32, geo_blocks, 8'd0, 32'd0, 8'd0);
    send(sfcs_pkg::ACT_BE32, geo_blocks - 1, 8'd0, 32'd0, 8'd0);
    send(sfcs_pkg::ACT_REPLY, 32'd0, 8'd0, 32'd0, 8'h00);
    send(sfcs_pkg::ACT_CE, 32'd0, 8'd0, 32'd0, 8'd0);
    send(sfcs_pkg::ACT_TICK, 32'd0, 8'd0, 32'd0, 8'd0);
    send(sfcs_pkg::ACT_REPLY, 32'd0, 8'd0, 32'd0, 8'h00);

    // program left to run into its tick limit
    send(sfcs_pkg::ACT_PROGRAM, 32'd0, 8'd0, 32'd16, 8'd0);
    repeat (sfcs_pkg::LIMIT_PROGRAM)
      send(sfcs_pkg::ACT_TICK, $urandom, 8'($urandom), $urandom, 8'($urandom));

    run_traffic(30);

    // random traffic across geometries; one phase with no idling at all
    for (int p = 0; p < 5; p++) begin
      settle(8);
      set_geometry(pg_list[p], sec_list[p], blk_list[p]);
      quiet = (p == 2);
      run_traffic(30);
    end
    quiet = 1'b0;

    settle(64);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
